// ----- rtl/mmfn_pkg.sv -----
package mmfn_pkg;

    localparam int DATA_W     = 32;
    localparam int INDEX_W    = 6;
    localparam int PADDR_W    = 3;
    localparam int DIV_STEPS  = 32;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic OP_OBSERVE   = 1'b0;
    localparam logic OP_NORMALIZE = 1'b1;

    localparam logic REG_LO_LIMIT = 1'b0;
    localparam logic REG_HI_LIMIT = 1'b1;

    localparam logic signed [DATA_W-1:0] LO_LIMIT_RESET = 32'sd0;
    localparam logic signed [DATA_W-1:0] HI_LIMIT_RESET = 32'sd65536;

    localparam logic signed [DATA_W-1:0] MIN_RESET = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] MAX_RESET = 32'sh8000_0000;

    typedef struct packed {
        logic                     op;
        logic [INDEX_W-1:0]       elem_index;
        logic signed [DATA_W-1:0] sample;
        logic                     batch_first;
    } req_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] scaled;
        logic [INDEX_W-1:0]       out_index;
        logic                     degenerate;
    } rsp_item_t;

    typedef struct packed {
        logic clear_step;
        logic load_item;
        logic obs_write;
        logic eval;
        logic mul;
        logic div_step;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic is_norm;
        logic degen;
        logic clear_last;
    } dp_status_t;

endpackage

// ----- rtl/mmfn_regs.sv -----
module mmfn_regs
    import mmfn_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready,
    output logic signed [DATA_W-1:0] lo_limit,
    output logic signed [DATA_W-1:0] hi_limit
);

    logic signed [DATA_W-1:0] lo_limit_reg;
    logic signed [DATA_W-1:0] hi_limit_reg;
    logic                     reg_sel;
    logic                     wr_en;

    assign reg_sel = paddr[2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_limit_reg <= LO_LIMIT_RESET;
            hi_limit_reg <= HI_LIMIT_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_LO_LIMIT: lo_limit_reg <= signed'(pwdata);
                REG_HI_LIMIT: hi_limit_reg <= signed'(pwdata);
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_LO_LIMIT: prdata = lo_limit_reg;
            REG_HI_LIMIT: prdata = hi_limit_reg;
        endcase
    end

    assign lo_limit = lo_limit_reg;
    assign hi_limit = hi_limit_reg;

endmodule

// ----- rtl/mmfn_ctrl.sv -----
module mmfn_ctrl
    import mmfn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_EVAL  = 6'b000100,
        S_MUL   = 6'b001000,
        S_DIV   = 6'b010000,
        S_FIN   = 6'b100000
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [DIV_CNT_W-1:0] div_cnt_next;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        req_ready    = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (!status.is_norm)
                begin
                    cmd.obs_write = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    cmd.eval   = 1'b1;
                    state_next = status.degen ? S_FIN : S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul      = 1'b1;
                div_cnt_next = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            div_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

// ----- rtl/mmfn_datapath.sv -----
module mmfn_datapath
    import mmfn_pkg::*;
#(
    parameter int DIMS = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  req_item_t                req,
    output rsp_item_t                rsp,
    input  logic signed [DATA_W-1:0] lo_limit,
    input  logic signed [DATA_W-1:0] hi_limit,
    input  dp_cmd_t                  cmd,
    output dp_status_t               status
);

    localparam int AW    = (DIMS > 1) ? $clog2(DIMS) : 1;
    localparam int CMP_W = ($clog2(DIMS + 1) > INDEX_W) ? $clog2(DIMS + 1) : INDEX_W;

    logic [2*DATA_W-1:0] mem [DIMS];

    req_item_t                req_reg;
    logic [2*DATA_W-1:0]      rd_data_reg;
    logic [AW-1:0]            clear_cnt_reg;
    logic [DATA_W-1:0]        num_reg;
    logic [DATA_W-1:0]        range_reg;
    logic [DATA_W-1:0]        mag_reg;
    logic                     neg_reg;
    logic                     degen_reg;
    logic [DATA_W-1:0]        rem_reg;
    logic [DATA_W-1:0]        quo_reg;
    logic [DATA_W-1:0]        rem_next;
    logic [DATA_W-1:0]        quo_next;
    rsp_item_t                rsp_reg;

    logic signed [DATA_W-1:0] mn;
    logic signed [DATA_W-1:0] mx;
    logic signed [DATA_W-1:0] v;
    logic signed [DATA_W-1:0] clamped;
    logic signed [DATA_W-1:0] new_min;
    logic signed [DATA_W-1:0] new_max;
    logic signed [DATA_W:0]   num_wide;
    logic signed [DATA_W:0]   range_wide;
    logic signed [DATA_W:0]   span;
    logic signed [DATA_W:0]   span_abs;
    logic                     oob;
    logic                     degen;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [2*DATA_W-1:0]      wr_data;
    logic [DATA_W:0]          trial;
    logic [DATA_W:0]          diff;
    logic                     ge;
    logic [DATA_W-1:0]        res;

    assign mn = signed'(rd_data_reg[DATA_W-1:0]);
    assign mx = signed'(rd_data_reg[2*DATA_W-1:DATA_W]);
    assign v  = req_reg.sample;

    assign oob   = CMP_W'(req_reg.elem_index) >= CMP_W'(DIMS);
    assign degen = oob || !(mx > mn);

    always_comb
    begin
        clamped = v;
        if (v > mx)
        begin
            clamped = mx;
        end
        if (v < mn)
        begin
            clamped = mn;
        end
    end

    assign new_min = (req_reg.batch_first || v < mn) ? v : mn;
    assign new_max = (req_reg.batch_first || v > mx) ? v : mx;

    assign num_wide   = 33'(clamped) - 33'(mn);
    assign range_wide = 33'(mx) - 33'(mn);
    assign span       = 33'(hi_limit) - 33'(lo_limit);
    assign span_abs   = span[DATA_W] ? -span : span;

    always_comb
    begin
        if (cmd.clear_step)
        begin
            wr_en   = 1'b1;
            wr_addr = clear_cnt_reg;
            wr_data = {MAX_RESET, MIN_RESET};
        end
        else
        begin
            wr_en   = cmd.obs_write && !oob;
            wr_addr = AW'(req_reg.elem_index);
            wr_data = {new_max, new_min};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.load_item)
        begin
            rd_data_reg <= mem[AW'(req.elem_index)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clear_cnt_reg <= clear_cnt_reg + 1'b1;
        end
    end

    assign trial    = {rem_reg, quo_reg[DATA_W-1]};
    assign diff     = trial - {1'b0, range_reg};
    assign ge       = trial >= {1'b0, range_reg};
    assign rem_next = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
    assign quo_next = {quo_reg[DATA_W-2:0], ge};

    assign res = neg_reg ? (lo_limit - quo_reg) : (lo_limit + quo_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            req_reg <= req;
        end
        if (cmd.eval)
        begin
            num_reg   <= num_wide[DATA_W-1:0];
            range_reg <= range_wide[DATA_W-1:0];
            mag_reg   <= span_abs[DATA_W-1:0];
            neg_reg   <= span[DATA_W];
            degen_reg <= degen;
        end
        if (cmd.mul)
        begin
            {rem_reg, quo_reg} <= num_reg * mag_reg;
        end
        if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
        if (cmd.out_load)
        begin
            rsp_reg.scaled     <= degen_reg ? lo_limit : signed'(res);
            rsp_reg.out_index  <= req_reg.elem_index;
            rsp_reg.degenerate <= degen_reg;
        end
    end

    assign rsp               = rsp_reg;
    assign status.is_norm    = req_reg.op == OP_NORMALIZE;
    assign status.degen      = degen;
    assign status.clear_last = clear_cnt_reg == AW'(DIMS - 1);

endmodule

// ----- rtl/minmax_feature_normalizer.sv -----
// Min-max feature normalizer, signed Q16.16, one vector element per transaction.
// req channel (valid/ready): op, elem_index, sample, batch_first. An observe
// transaction folds sample into the stored min/max of its dimension (or loads
// both when batch_first is set) and returns nothing. A normalize transaction
// returns one rsp transaction: the sample clamped to [min,max] and mapped onto
// [lo_limit,hi_limit], with degenerate set and scaled = lo_limit when max <= min or elem_index >= DIMS.
// APB port: lo_limit at 0x0, hi_limit at 0x4; write only while idle.
// Items are handled one at a time; req_ready is high only when the block is idle.
// Observe: min/max read, then the updated min/max written back. Degenerate normalize:
// min/max read, evaluation, output load. Normalize: min/max read, evaluation, one
// 32x32 multiply, 32 steps of a one-bit-per-cycle restoring divider, output load.
// Reset: limits return to 0 and 1.0; a clearing pass then writes every dimension
// back to min = most positive, max = most negative, and req_ready stays low
// until it ends.
// A stalled rsp holds in the output register; a further normalize waits at
// its last step until that result is taken, an observe does not wait.
module minmax_feature_normalizer
    import mmfn_pkg::*;
#(
    parameter int DIMS = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  req_item_t          req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output rsp_item_t          rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    logic signed [DATA_W-1:0] lo_limit;
    logic signed [DATA_W-1:0] hi_limit;
    dp_cmd_t                  cmd;
    dp_status_t               status;

    mmfn_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .lo_limit (lo_limit),
        .hi_limit (hi_limit)
    );

    mmfn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .cmd       (cmd)
    );

    mmfn_datapath #(
        .DIMS (DIMS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .lo_limit (lo_limit),
        .hi_limit (hi_limit),
        .cmd      (cmd),
        .status   (status)
    );

    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready
    ) else $error("req_ready high in the cycle after an accepted transaction");

    a_observe_no_rsp: assert property (
        @(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req.op == OP_OBSERVE && !rsp_valid |=> !rsp_valid
    ) else $error("observe transaction produced a response");

    a_rsp_rise_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> req_ready
    ) else $error("response loaded while controller not returning to idle");

endmodule

// ----- tb/minmax_norm_checker.sv -----
`timescale 1ns / 1ps

module minmax_norm_checker
    import mmfn_pkg::*;
#(
    parameter int DIMS = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_ready,
    input  req_item_t          req,
    input  logic               rsp_valid,
    input  logic               rsp_ready,
    input  rsp_item_t          rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output int                 mismatches,
    output int                 outstanding
);

    logic signed [DATA_W-1:0] lo_lim;
    logic signed [DATA_W-1:0] hi_lim;
    logic signed [DATA_W-1:0] min_tab [DIMS];
    logic signed [DATA_W-1:0] max_tab [DIMS];
    rsp_item_t                expected_scaled_q [$];
    rsp_item_t                oldest;
    int                       dim;

    task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] expected,
                                 input logic [DATA_W-1:0] actual);
        begin
            $display("%0t mismatch %s: expected %h got %h", $time, what, expected, actual);
            mismatches++;
        end
    endtask

    function automatic rsp_item_t predict_scaled(input logic [INDEX_W-1:0] idx,
                                                 input logic signed [DATA_W-1:0] s);
        rsp_item_t           r;
        logic signed [63:0]  mn;
        logic signed [63:0]  mx;
        logic signed [63:0]  v;
        logic signed [63:0]  lo64;
        logic signed [63:0]  hi64;
        logic signed [63:0]  span;
        logic signed [63:0]  res;
        logic [63:0]         range;
        logic [63:0]         num;
        logic [63:0]         mag;
        logic [63:0]         q;
        logic                neg;
        begin
            r.out_index = idx;
            if (idx >= DIMS || max_tab[idx] <= min_tab[idx]) begin
                r.scaled     = lo_lim;
                r.degenerate = 1'b1;
                return r;
            end
            mn = min_tab[idx];
            mx = max_tab[idx];
            v  = s;
            if (v > mx) v = mx;
            if (v < mn) v = mn;
            range = mx - mn;
            num   = v - mn;
            lo64  = lo_lim;
            hi64  = hi_lim;
            span  = hi64 - lo64;
            neg   = span < 0;
            mag   = neg ? -span : span;
            q     = (num * mag) / range;
            res   = neg ? lo64 - q : lo64 + q;
            r.scaled     = res[DATA_W-1:0];
            r.degenerate = 1'b0;
            return r;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_lim = LO_LIMIT_RESET;
            hi_lim = HI_LIMIT_RESET;
            for (dim = 0; dim < DIMS; dim++)
            begin
                min_tab[dim] = MIN_RESET;
                max_tab[dim] = MAX_RESET;
            end
            expected_scaled_q.delete();
            outstanding = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[2])
                    REG_LO_LIMIT: lo_lim = pwdata;
                    REG_HI_LIMIT: hi_lim = pwdata;
                endcase
            end
            if (rsp_valid && rsp_ready)
            begin
                if (expected_scaled_q.size() == 0)
                    flag_mismatch("result with no normalize pending", '0, rsp.scaled);
                else
                begin
                    oldest = expected_scaled_q.pop_front();
                    if (rsp.scaled !== oldest.scaled)
                        flag_mismatch("scaled", oldest.scaled, rsp.scaled);
                    if (rsp.out_index !== oldest.out_index)
                        flag_mismatch("out_index", 32'(oldest.out_index), 32'(rsp.out_index));
                    if (rsp.degenerate !== oldest.degenerate)
                        flag_mismatch("degenerate", 32'(oldest.degenerate),
                                      32'(rsp.degenerate));
                end
            end
            if (req_valid && req_ready)
            begin
                if (req.op == OP_NORMALIZE)
                    expected_scaled_q.push_back(predict_scaled(req.elem_index, req.sample));
                else if (req.elem_index < DIMS)
                begin
                    if (req.batch_first)
                    begin
                        min_tab[req.elem_index] = req.sample;
                        max_tab[req.elem_index] = req.sample;
                    end
                    else
                    begin
                        if (req.sample < min_tab[req.elem_index])
                            min_tab[req.elem_index] = req.sample;
                        if (req.sample > max_tab[req.elem_index])
                            max_tab[req.elem_index] = req.sample;
                    end
                end
            end
            outstanding = expected_scaled_q.size();
        end
    end

endmodule

// ----- tb/minmax_feature_normalizer_test.sv -----
`timescale 1ns / 1ps

module minmax_feature_normalizer_test;
    import mmfn_pkg::*;

    localparam int DIMS         = 64;
    localparam int PHASES       = 7;
    localparam int PHASE_ITEMS  = 250;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 600000;

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_ready;
    req_item_t          req;
    logic               rsp_valid;
    logic               rsp_ready;
    rsp_item_t          rsp;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    int                 mismatches;
    int                 outstanding;
    int                 cycle_count;
    logic               quiet;

    logic [DATA_W-1:0]  lo_set [PHASES];
    logic [DATA_W-1:0]  hi_set [PHASES];
    int                 phase;

    minmax_feature_normalizer #(.DIMS(DIMS)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    minmax_norm_checker #(.DIMS(DIMS)) checker_i
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ready = quiet ? 1'b1 : ($urandom_range(99) >= 18);
        end
    end

    function automatic req_item_t make_item(input logic op, input logic [INDEX_W-1:0] idx,
                                            input logic [DATA_W-1:0] s, input logic first);
        req_item_t it;
        begin
            it.op          = op;
            it.elem_index  = idx;
            it.sample      = s;
            it.batch_first = first;
            return it;
        end
    endfunction

    function automatic logic [DATA_W-1:0] pick_sample();
        begin
            case ($urandom_range(5))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'($signed($urandom_range(131072)) - 65536);
                default: return $urandom;
            endcase
        end
    endfunction

    task automatic send_item(input req_item_t item);
        begin
            while (!quiet && $urandom_range(99) < 18)
            begin
                req_valid = 1'b0;
                @(negedge clk);
            end
            req       = item;
            req_valid = 1'b1;
            @(posedge clk);
            while (!req_ready)
                @(posedge clk);
            @(negedge clk);
        end
    endtask

    task automatic write_limit(input logic reg_sel, input logic [DATA_W-1:0] value);
        begin
            psel    = 1'b1;
            pwrite  = 1'b1;
            penable = 1'b0;
            paddr   = {reg_sel, 2'b00};
            pwdata  = value;
            @(negedge clk);
            penable = 1'b1;
            @(posedge clk);
            while (!pready)
                @(posedge clk);
            @(negedge clk);
            psel    = 1'b0;
            penable = 1'b0;
            pwrite  = 1'b0;
        end
    endtask

    task automatic drain();
        begin
            req_valid = 1'b0;
            while (outstanding != 0)
                @(negedge clk);
            repeat (DRAIN_CYCLES) @(negedge clk);
        end
    endtask

    task automatic run_traffic(input int count);
        int                 sent;
        int                 mode;
        int                 n_dims;
        int                 base;
        int                 vecs;
        int                 n_norm;
        int                 k;
        int                 d;
        begin
            sent = 0;
            while (sent < count)
            begin
                mode = $urandom_range(9);
                if (mode < 6)
                begin
                    n_dims = $urandom_range(1, 6);
                    base   = $urandom_range(DIMS - 1);
                    vecs   = $urandom_range(1, 4);
                    for (k = 0; k < vecs; k++)
                        for (d = 0; d < n_dims; d++)
                        begin
                            send_item(make_item(OP_OBSERVE, INDEX_W'(base + d),
                                                pick_sample(), k == 0));
                            sent++;
                        end
                    n_norm = $urandom_range(1, 2 * n_dims);
                    for (k = 0; k < n_norm; k++)
                    begin
                        send_item(make_item(OP_NORMALIZE,
                                            INDEX_W'(base + $urandom_range(n_dims - 1)),
                                            pick_sample(), 1'($urandom_range(1))));
                        sent++;
                    end
                end
                else if (mode < 8)
                begin
                    send_item(make_item(1'($urandom_range(1)),
                                        INDEX_W'($urandom_range(DIMS - 1)),
                                        $urandom, 1'($urandom_range(1))));
                    sent++;
                end
                else
                begin
                    send_item(make_item(OP_OBSERVE, INDEX_W'($urandom_range(DIMS - 1)),
                                        pick_sample(), 1'b0));
                    send_item(make_item(OP_NORMALIZE, INDEX_W'($urandom_range(DIMS - 1)),
                                        pick_sample(), 1'b0));
                    sent += 2;
                end
            end
        end
    endtask

    initial
    begin
        quiet     = 1'b0;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;

        lo_set[0] = 32'h0000_0000;  hi_set[0] = 32'h0001_0000;
        lo_set[1] = 32'hFFFF_0000;  hi_set[1] = 32'h0001_0000;
        lo_set[2] = 32'h8000_0000;  hi_set[2] = 32'h7FFF_FFFF;
        lo_set[3] = 32'h0001_0000;  hi_set[3] = 32'h0000_0000;
        lo_set[4] = $urandom;       hi_set[4] = $urandom;
        lo_set[5] = 32'h7FFF_FFFF;  hi_set[5] = 32'h8000_0000;
        lo_set[6] = $urandom;       hi_set[6] = $urandom;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_item(make_item(OP_NORMALIZE, 6'd0, 32'h0000_0000, 1'b0));
        send_item(make_item(OP_OBSERVE, 6'd0, 32'h0000_0005, 1'b1));
        send_item(make_item(OP_NORMALIZE, 6'd0, 32'h0000_0005, 1'b0));
        send_item(make_item(OP_OBSERVE, 6'd63, 32'h8000_0000, 1'b1));
        send_item(make_item(OP_OBSERVE, 6'd63, 32'h7FFF_FFFF, 1'b0));
        send_item(make_item(OP_NORMALIZE, 6'd63, 32'h8000_0000, 1'b0));
        send_item(make_item(OP_NORMALIZE, 6'd63, 32'h7FFF_FFFF, 1'b0));
        send_item(make_item(OP_NORMALIZE, 6'd63, 32'h0000_0000, 1'b0));
        send_item(make_item(OP_NORMALIZE, 6'd63, 32'h0000_3039, 1'b1));
        send_item(make_item(OP_OBSERVE, 6'd1, 32'hFFFF_0000, 1'b1));
        send_item(make_item(OP_OBSERVE, 6'd1, 32'h0001_0000, 1'b0));
        send_item(make_item(OP_OBSERVE, 6'd1, 32'h0000_0000, 1'b0));
        send_item(make_item(OP_NORMALIZE, 6'd1, 32'hC000_0000, 1'b0));
        send_item(make_item(OP_NORMALIZE, 6'd1, 32'h4000_0000, 1'b0));
        send_item(make_item(OP_NORMALIZE, 6'd1, 32'h0000_8000, 1'b0));
        send_item(make_item(OP_OBSERVE, 6'd1, 32'h0000_0064, 1'b1));
        send_item(make_item(OP_NORMALIZE, 6'd1, 32'h0000_0064, 1'b0));

        drain();
        write_limit(REG_LO_LIMIT, 32'h8000_0000);
        write_limit(REG_HI_LIMIT, 32'h7FFF_FFFF);
        send_item(make_item(OP_NORMALIZE, 6'd63, 32'h7FFF_FFFF, 1'b0));
        send_item(make_item(OP_NORMALIZE, 6'd63, 32'h0000_0000, 1'b0));

        drain();
        write_limit(REG_LO_LIMIT, 32'h7FFF_FFFF);
        write_limit(REG_HI_LIMIT, 32'h8000_0000);
        send_item(make_item(OP_NORMALIZE, 6'd63, 32'h4000_0000, 1'b0));
        send_item(make_item(OP_NORMALIZE, 6'd63, 32'h8000_0000, 1'b0));

        for (phase = 0; phase < PHASES; phase++)
        begin
            drain();
            write_limit(REG_LO_LIMIT, lo_set[phase]);
            write_limit(REG_HI_LIMIT, hi_set[phase]);
            quiet = (phase == 3);
            run_traffic(PHASE_ITEMS);
        end
        quiet = 1'b0;

        drain();
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
